/* hw/rtl/spc_pkg.sv */
// ----------------------------------------------------------------------------
// spc_pkg
// Shared types, constants and the CRC-8/Maxim byte update for the sensor
// packet checker.
// ----------------------------------------------------------------------------
package spc_pkg;

    localparam int FRAME_BYTES  = 8;
    localparam int COUNT_W      = $clog2(FRAME_BYTES);
    localparam int HELD_DEPTH   = FRAME_BYTES - 1;
    localparam int SENSOR_W     = 2;
    localparam int CFG_INDEX_W  = 2;
    localparam int CFG_DATA_W   = 8;

    localparam logic [7:0] CRC_XOR_LOW = 8'h0c;
    localparam logic [7:0] CRC_TOP_BIT = 8'h80;
    localparam logic [7:0] BRIDGE_BIT  = 8'h02;

    // frame layout
    localparam int ID_POS   = 0;
    localparam int DATA_POS = 2;
    localparam int MASK_POS = 6;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD      = 2'd1,
        ST_BROKEN   = 2'd2,
        ST_NO_REPLY = 2'd3
    } frame_status_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIRST_ID  = 2'd0,
        REG_SECOND_ID = 2'd1,
        REG_THIRD_ID  = 2'd2,
        REG_RETRY     = 2'd3
    } cfg_reg_t;

    // counter update request for one accepted beat
    typedef struct packed {
        logic                bad_inc;
        logic                bad_clr;
        logic                nr_inc;
        logic                nr_clr;
        logic [SENSOR_W-1:0] sensor;
    } cnt_req_t;

    typedef struct packed {
        frame_status_t       status;
        logic                alarm;
        logic [SENSOR_W-1:0] sensor;
        logic [7:0]          id;
        logic [31:0]         payload;
        logic [7:0]          mask;
    } result_t;

    // reflected crc-8, lsb first, one bit per step
    function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                             input logic [7:0] data);
        logic [7:0] crc;
        logic [7:0] b;
        crc = crc_in;
        b   = data;
        for (int k = 0; k < 8; k++)
        begin
            if ((crc[0] ^ b[0]) == 1'b1)
            begin
                crc = (crc >> 1) ^ CRC_XOR_LOW ^ CRC_TOP_BIT;
            end
            else
            begin
                crc = crc >> 1;
            end
            b = b >> 1;
        end
        return crc;
    endfunction

endpackage

/* hw/rtl/spc_err_counters.sv */
// ----------------------------------------------------------------------------
// spc_err_counters
// Per-sensor counters of consecutive bad frames and no-replies; raises the
// alarm and clears a counter when it reaches the retry limit.
// ----------------------------------------------------------------------------
module spc_err_counters
    import spc_pkg::*;
#(
    parameter int SENSOR_COUNT = 3
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  cnt_req_t   req,
    input  logic [7:0] retry_limit,
    output logic       alarm
);

    logic [7:0]              bad_cnt_reg [SENSOR_COUNT];
    logic [7:0]              nr_cnt_reg  [SENSOR_COUNT];
    logic [SENSOR_COUNT-1:0] lane_alarm;

    for (genvar i = 0; i < SENSOR_COUNT; i++)
    begin : g_lane
        logic       sel;
        logic [7:0] bad_bump;
        logic [7:0] nr_bump;
        logic       bad_hit;
        logic       nr_hit;
        logic [7:0] bad_next;
        logic [7:0] nr_next;

        assign sel      = ({1'b0, req.sensor} == 3'(i));
        assign bad_bump = bad_cnt_reg[i] + 8'd1;
        assign nr_bump  = nr_cnt_reg[i] + 8'd1;
        assign bad_hit  = (bad_bump >= retry_limit);
        assign nr_hit   = (nr_bump >= retry_limit);

        always_comb
        begin
            bad_next = bad_cnt_reg[i];
            nr_next  = nr_cnt_reg[i];
            if (sel && req.bad_inc)
            begin
                bad_next = bad_hit ? 8'd0 : bad_bump;
            end
            else if (sel && req.bad_clr)
            begin
                bad_next = 8'd0;
            end
            if (sel && req.nr_inc)
            begin
                nr_next = nr_hit ? 8'd0 : nr_bump;
            end
            else if (sel && req.nr_clr)
            begin
                nr_next = 8'd0;
            end
        end

        assign lane_alarm[i] = sel && ((req.bad_inc && bad_hit) || (req.nr_inc && nr_hit));

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                bad_cnt_reg[i] <= 8'd0;
                nr_cnt_reg[i]  <= 8'd0;
            end
            else
            begin
                bad_cnt_reg[i] <= bad_next;
                nr_cnt_reg[i]  <= nr_next;
            end
        end
    end

    assign alarm = |lane_alarm;

endmodule

/* hw/rtl/sensor_packet_checker.sv */
// ----------------------------------------------------------------------------
// sensor_packet_checker
// Receiver-side checker for 8-byte sensor frames protected by CRC-8/Maxim.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one received byte per beat, with the
// polled sensor index and a timeout flag. A timeout beat carries no byte,
// drops any partial frame and counts a no-reply for that sensor.
// Output channel (out_valid / out_stall): one result per completed frame
// (the eighth byte) or per timeout; the other beats give no result.
// Throughput is one input beat per cycle while in_stall is low; the path that
// sets it is the eight-step CRC byte update plus the ID/data checks, all
// combinational. An accepted beat's result is registered in the output
// register; while a stalled result sits there, one more result goes into a
// skid register, and in_stall rises only while that skid register is full.
// Configuration (cfg_we/cfg_index/cfg_data) is user-written only while idle;
// the block does not enforce it. Reset clears the frame position, running
// CRC and error counters, sets IDs 1, 2, 3, retry limit 3. No clearing pass.
// ----------------------------------------------------------------------------
module sensor_packet_checker
    import spc_pkg::*;
#(
    parameter int SENSOR_COUNT = 3
)
(
    input  logic                   clk,
    input  logic                   rst_n,

    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,

    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [7:0]             rx_byte,
    input  logic [SENSOR_W-1:0]    sensor_index,
    input  logic                   timed_out,

    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [1:0]             frame_status,
    output logic                   alarm,
    output logic [SENSOR_W-1:0]    alarm_sensor,
    output logic [7:0]             frame_id,
    output logic [31:0]            payload,
    output logic [7:0]             mask_byte
);

    logic [7:0]         first_id_reg;
    logic [7:0]         second_id_reg;
    logic [7:0]         third_id_reg;
    logic [7:0]         retry_limit_reg;

    logic [COUNT_W-1:0] byte_count_reg;
    logic [COUNT_W-1:0] byte_count_next;
    logic [7:0]         crc_reg;
    logic [7:0]         crc_next;
    logic [7:0]         held_reg [HELD_DEPTH];

    result_t            out_reg;
    result_t            out_next;
    logic               out_valid_reg;
    logic               out_valid_next;
    result_t            skid_reg;
    result_t            skid_next;
    logic               skid_valid_reg;
    logic               skid_valid_next;

    logic               accept_in;
    logic               last_byte;
    logic               res_fire;
    logic               out_take;
    logic [7:0]         crc_upd;
    logic               id_bad;
    logic               data_zero;
    logic               frame_bad;
    logic               bridge;
    logic               cnt_alarm;
    cnt_req_t           cnt_req;
    result_t            res;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_id_reg    <= 8'd1;
            second_id_reg   <= 8'd2;
            third_id_reg    <= 8'd3;
            retry_limit_reg <= 8'd3;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_FIRST_ID:  first_id_reg    <= cfg_data;
                REG_SECOND_ID: second_id_reg   <= cfg_data;
                REG_THIRD_ID:  third_id_reg    <= cfg_data;
                REG_RETRY:     retry_limit_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    assign in_stall  = skid_valid_reg;
    assign accept_in = in_valid && !in_stall;
    assign out_take  = out_valid_reg && !out_stall;
    assign last_byte = (byte_count_reg == COUNT_W'(HELD_DEPTH));
    assign res_fire  = accept_in && (timed_out || last_byte);

    // frame evaluation on the final byte
    assign crc_upd   = crc8_byte(crc_reg, rx_byte);
    assign id_bad    = (held_reg[ID_POS] != first_id_reg) &&
                       (held_reg[ID_POS] != second_id_reg) &&
                       (held_reg[ID_POS] != third_id_reg);
    assign data_zero = ((held_reg[DATA_POS] | held_reg[DATA_POS+1] |
                         held_reg[DATA_POS+2] | held_reg[DATA_POS+3]) == 8'd0);
    assign frame_bad = id_bad || data_zero || (crc_upd != 8'd0);
    assign bridge    = ((held_reg[MASK_POS] & BRIDGE_BIT) != 8'd0);

    always_comb
    begin
        cnt_req        = '0;
        cnt_req.sensor = sensor_index;
        if (res_fire)
        begin
            if (timed_out)
            begin
                cnt_req.nr_inc = 1'b1;
            end
            else if (frame_bad)
            begin
                cnt_req.bad_inc = 1'b1;
            end
            else
            begin
                cnt_req.bad_clr = 1'b1;
                cnt_req.nr_clr  = !bridge;
            end
        end
    end

    spc_err_counters #(
        .SENSOR_COUNT (SENSOR_COUNT)
    ) u_counters (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (cnt_req),
        .retry_limit (retry_limit_reg),
        .alarm       (cnt_alarm)
    );

    always_comb
    begin
        res         = '0;
        res.sensor  = sensor_index;
        res.alarm   = cnt_alarm;
        if (timed_out)
        begin
            res.status = ST_NO_REPLY;
        end
        else
        begin
            res.id   = held_reg[ID_POS];
            res.mask = held_reg[MASK_POS];
            if (frame_bad)
            begin
                res.status = ST_BAD;
            end
            else if (bridge)
            begin
                res.status = ST_BROKEN;
            end
            else
            begin
                res.status  = ST_OK;
                res.payload = {held_reg[DATA_POS+3], held_reg[DATA_POS+2],
                               held_reg[DATA_POS+1], held_reg[DATA_POS]};
            end
        end
    end

    // frame position and running crc
    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        if (accept_in)
        begin
            if (timed_out || last_byte)
            begin
                byte_count_next = '0;
                crc_next        = 8'd0;
            end
            else
            begin
                byte_count_next = byte_count_reg + COUNT_W'(1);
                crc_next        = crc_upd;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg <= '0;
            crc_reg        <= 8'd0;
        end
        else
        begin
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept_in && !timed_out && !last_byte)
        begin
            held_reg[byte_count_reg] <= rx_byte;
        end
    end

    // output register with one skid entry
    always_comb
    begin
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (!out_valid_reg || out_take)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
            else if (res_fire)
            begin
                out_next       = res;
                out_valid_next = 1'b1;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
        else if (res_fire)
        begin
            skid_next       = res;
            skid_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid    = out_valid_reg;
    assign frame_status = out_reg.status;
    assign alarm        = out_reg.alarm;
    assign alarm_sensor = out_reg.sensor;
    assign frame_id     = out_reg.id;
    assign payload      = out_reg.payload;
    assign mask_byte    = out_reg.mask;

    // skid entry is only used behind a full output register
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds a beat while the output register is empty");

    a_timeout_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && timed_out |=> (byte_count_reg == '0) && (crc_reg == 8'd0))
        else $error("timeout did not restart the frame");

    a_byte_advances: assert property (@(posedge clk) disable iff (!rst_n)
        accept_in && !timed_out && !last_byte |=>
            byte_count_reg == COUNT_W'($past(byte_count_reg) + COUNT_W'(1)))
        else $error("frame position did not advance");

    a_good_no_alarm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && (out_reg.status == ST_OK || out_reg.status == ST_BROKEN)
            |-> !out_reg.alarm)
        else $error("alarm raised on a frame that passed the checks");

    a_timeout_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.status == ST_NO_REPLY
            |-> (out_reg.id == 8'd0) && (out_reg.payload == 32'd0))
        else $error("timeout result carries frame data");

endmodule
